>>> src/pnd_pkg.sv
// ----------------------------------------------------------------------------
// pnd_pkg
// Shared types and constants for the fractal 2-D gradient noise block.
// ----------------------------------------------------------------------------
package pnd_pkg;

  // lattice table size and address width
  localparam int TABLE_SIZE = 256;
  localparam int TBL_BITS   = 8;

  // scaled coordinate: product >> (16 + TBL_BITS), clamped product width
  localparam int SCALE_SHIFT = 16 + TBL_BITS;
  localparam int M_W         = SCALE_SHIFT + 34;
  localparam logic [M_W-1:0] M_CAP = M_W'(1) << (M_W - 1);
  localparam logic [M_W:0]   M_RND = (M_W + 1)'((1 << SCALE_SHIFT) - 1);

  // fade polynomial constants in q16
  localparam logic signed [37:0] FADE_C15 = 38'sd983040;
  localparam logic signed [37:0] FADE_C10 = 38'sd655360;

  // amplitude of the first octave, q32.14
  localparam logic [45:0] AMP_ONE = 46'd16384;

  // command codes on tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD01  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD23  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD45  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD6   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd6;

  typedef struct packed {
    logic [63:0] grad01;
    logic [63:0] grad23;
    logic [63:0] grad45;
    logic [31:0] grad6;
    logic [4:0]  octaves;
    logic [31:0] freq;
    logic [14:0] persist;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_sample;
    logic [7:0]  entry_index;
    logic [7:0]  entry_value;
    logic        neg_x;
    logic [31:0] mag_x;
    logic        neg_y;
    logic [31:0] mag_y;
  } item_t;

endpackage

>>> src/perlin_noise_2d_octaves.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves
// Fractal 2-D gradient noise: load items fill the permutation table, sample
// items return the saturated octave sum of a q16.16 point.
// ----------------------------------------------------------------------------
// samples run one at a time through the shared octave datapath (table read
//   chain, dot, lerp and amplitude multiplies); a new sample is taken only
//   after the previous result has been handed to the output register
// loads retire one per cycle once they reach the head of the queue and the engine is idle
// reset: synchronous active low, clears control and sets configuration to defaults; the
//   permutation table keeps its contents and must be loaded before sampling
module perlin_noise_2d_octaves #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // entry_index, entry_value, point_x, point_y
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // noise_value
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] grad01_r, grad23_r, grad45_r;
  logic [31:0] grad6_r;
  logic [4:0]  octaves_r;
  logic [31:0] freq_r;
  logic [14:0] persist_r;

  pnd_pkg::cfg_t  cfg;
  pnd_pkg::item_t q_item;
  logic           q_valid, q_pop, busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad01_r  <= '0;
      grad23_r  <= '0;
      grad45_r  <= '0;
      grad6_r   <= '0;
      octaves_r <= 5'd1;
      freq_r    <= 32'd16777216;
      persist_r <= 15'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        pnd_pkg::CFG_GRAD01:  grad01_r  <= cfg_wdata;
        pnd_pkg::CFG_GRAD23:  grad23_r  <= cfg_wdata;
        pnd_pkg::CFG_GRAD45:  grad45_r  <= cfg_wdata;
        pnd_pkg::CFG_GRAD6:   grad6_r   <= cfg_wdata[31:0];
        pnd_pkg::CFG_OCTAVES: octaves_r <= cfg_wdata[4:0];
        pnd_pkg::CFG_FREQ:    freq_r    <= cfg_wdata[31:0];
        pnd_pkg::CFG_PERSIST: persist_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.grad01  = grad01_r;
    cfg.grad23  = grad23_r;
    cfg.grad45  = grad45_r;
    cfg.grad6   = grad6_r;
    cfg.octaves = octaves_r;
    cfg.freq    = freq_r;
    cfg.persist = persist_r;
  end

  pnd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item       (q_item),
    .item_valid (q_valid),
    .item_pop   (q_pop)
  );

  pnd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (q_item),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_noise  (out_tdata),
    .out_sat    (out_tuser)
  );

  // the engine never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a sample taken from the queue starts the octave engine
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.is_sample |=> busy)
    else $error("sample popped without engine start");

  // a result appears only at the end of a sample run
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy))
    else $error("result without a sample in flight");

endmodule

>>> src/pnd_front.sv
// ----------------------------------------------------------------------------
// pnd_front
// Accepts input items, splits sample points into sign and magnitude and
// holds them in a short queue for the octave engine.
// ----------------------------------------------------------------------------
module pnd_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [79:0]    in_tdata,
  input  logic           in_tuser,
  output pnd_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pnd_pkg::item_t queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  pnd_pkg::item_t   cls;
  logic             push;
  logic signed [31:0] px, py;

  assign px = in_tdata[47:16];
  assign py = in_tdata[79:48];

  always_comb begin
    cls.is_sample   = (in_tuser == pnd_pkg::CMD_SAMPLE);
    cls.entry_index = in_tdata[7:0];
    cls.entry_value = in_tdata[15:8];
    cls.neg_x       = px[31];
    cls.mag_x       = px[31] ? 32'(32'd0 - px) : px;
    cls.neg_y       = py[31];
    cls.mag_y       = py[31] ? 32'(32'd0 - py) : py;
  end

  assign in_tready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign item_valid = (count_r != '0);
  assign item       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (item_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !item_pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (!push && item_pop) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

>>> src/pnd_fade.sv
// ----------------------------------------------------------------------------
// pnd_fade
// Three-stage pipeline for the 6t^5-15t^4+10t^3 fade of a q0.16 fraction.
// ----------------------------------------------------------------------------
module pnd_fade (
  input  logic        clk,
  input  logic [15:0] t,
  output logic [19:0] f
);

  logic [15:0]        t1_r;
  logic [31:0]        tt_r;
  logic signed [37:0] tq_r;
  logic [31:0]        t3p_r;
  logic [19:0]        q_r;
  logic [19:0]        f_r;
  logic signed [37:0] ts;
  logic signed [37:0] qs;
  logic [35:0]        fp;

  assign ts = $signed({22'd0, t});
  assign qs = (tq_r >>> 16) + pnd_pkg::FADE_C10;
  assign fp = {20'd0, t3p_r[31:16]} * {16'd0, q_r};

  always_ff @(posedge clk) begin
    t1_r  <= t;
    tt_r  <= {16'd0, t} * {16'd0, t};
    tq_r  <= ts * (38'sd6 * ts - pnd_pkg::FADE_C15);
    t3p_r <= {16'd0, tt_r[31:16]} * {16'd0, t1_r};
    q_r   <= qs[19:0];
    f_r   <= fp[35:16];
  end

  assign f = f_r;

endmodule

>>> src/pnd_back.sv
// ----------------------------------------------------------------------------
// pnd_back
// Octave engine: permutation table, coordinate scaling, corner gradients,
// fade blend and amplitude-weighted sum, with the result register.
// ----------------------------------------------------------------------------
module pnd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pnd_pkg::cfg_t  cfg,
  input  pnd_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_pop,
  output logic           busy,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_noise,
  output logic           out_sat
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_INIT   = 4'd2;
  localparam logic [3:0] ST_SCALE  = 4'd3;
  localparam logic [3:0] ST_ADDR   = 4'd4;
  localparam logic [3:0] ST_RD_IN  = 4'd5;
  localparam logic [3:0] ST_RD_B   = 4'd6;
  localparam logic [3:0] ST_RD_T   = 4'd7;
  localparam logic [3:0] ST_DOT_T  = 4'd8;
  localparam logic [3:0] ST_LERP1  = 4'd9;
  localparam logic [3:0] ST_LERP2  = 4'd10;
  localparam logic [3:0] ST_TMUL   = 4'd11;
  localparam logic [3:0] ST_ACCUM  = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  localparam int MW = pnd_pkg::M_W;
  localparam int SS = pnd_pkg::SCALE_SHIFT;

  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // returns {clamped, value}
  function automatic logic [32:0] scale(input logic [MW-1:0] m, input logic neg);
    logic [33:0] qp;
    logic [MW:0] mr;
    logic [34:0] qn;
    logic        sat;
    logic [31:0] v;
    qp = m[MW-1:SS];
    mr = {1'b0, m} + pnd_pkg::M_RND;
    qn = mr[MW:SS];
    sat = 1'b0;
    if (!neg) begin
      if (qp > 34'h07FFFFFFF) begin
        sat = 1'b1;
        v = 32'h7FFFFFFF;
      end else begin
        v = qp[31:0];
      end
    end else begin
      if (qn > 35'h080000000) begin
        sat = 1'b1;
        v = 32'h80000000;
      end else begin
        v = 32'd0 - qn[31:0];
      end
    end
    return {sat, v};
  endfunction

  function automatic logic [7:0] cell_idx(input logic signed [16:0] c);
    logic [16:0] n;
    n = 17'(17'sd0 - c);
    return c[16] ? n[7:0] : c[7:0];
  endfunction

  function automatic logic [31:0] grad_sel(input pnd_pkg::cfg_t c, input logic [2:0] g);
    logic [31:0] w;
    case (g)
      3'd0:    w = c.grad01[31:0];
      3'd1:    w = c.grad01[63:32];
      3'd2:    w = c.grad23[31:0];
      3'd3:    w = c.grad23[63:32];
      3'd4:    w = c.grad45[31:0];
      3'd5:    w = c.grad45[63:32];
      3'd6:    w = c.grad6;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [21:0] dot(input logic signed [17:0] dx,
                                             input logic signed [17:0] dy,
                                             input logic [31:0] g);
    logic signed [15:0] gx, gy;
    logic signed [34:0] s;
    gx = g[15:0];
    gy = g[31:16];
    s = 35'(dx) * 35'(gx) + 35'(dy) * 35'(gy);
    return 22'(s >>> 14);
  endfunction

  function automatic logic signed [21:0] lerp(input logic signed [21:0] a,
                                              input logic signed [21:0] b,
                                              input logic [19:0] u);
    logic signed [44:0] d, p;
    d = 45'(b) - 45'(a);
    p = d * $signed({25'd0, u});
    return 22'(45'(a) + (p >>> 16));
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  table_r [pnd_pkg::TABLE_SIZE];
  logic [7:0]  addr_a, addr_b, rd_a_r, rd_b_r;
  logic        neg_x_r, neg_y_r;
  logic [31:0] mag_x_r, mag_y_r;
  logic [63:0] prod_x_r, prod_y_r;
  logic [MW-1:0] mx_r, my_r;
  logic [45:0] amp_r;
  logic signed [63:0] total_r;
  logic [4:0]  k_r;
  logic        sat_r;
  logic [31:0] sx_r, sy_r;
  logic [7:0]  px0_r, px1_r, inner1_r;
  logic [2:0]  g_bl_r, g_br_r, g_tl_r, g_tr_r;
  logic signed [21:0] w_bl_r, w_br_r, w_tl_r, w_tr_r;
  logic signed [21:0] a_r, b_r, n_r;
  logic signed [45:0] pn_lo_r, pn_hi_r;
  logic [37:0] pa_lo_r, pa_hi_r;
  logic        out_valid_r, out_sat_r;
  logic [31:0] out_noise_r;

  logic [32:0] scl_x, scl_y;
  logic [19:0] ux, uy;
  logic signed [17:0] dxl, dxr, dyb, dyt;
  logic signed [16:0] x0, y0;
  logic [7:0]  py0, py1;
  logic signed [69:0] term;
  logic [60:0] amp_full;
  logic [MW:0] mx_dbl, my_dbl;
  logic        out_free;

  pnd_fade u_fade_x (.clk(clk), .t(sx_r[15:0]), .f(ux));
  pnd_fade u_fade_y (.clk(clk), .t(sy_r[15:0]), .f(uy));

  assign scl_x = scale(mx_r, neg_x_r);
  assign scl_y = scale(my_r, neg_y_r);

  assign x0  = 17'($signed(sx_r[31:16]));
  assign y0  = 17'($signed(sy_r[31:16]));
  assign py0 = cell_idx(y0);
  assign py1 = cell_idx(17'(y0 + 17'sd1));

  assign dxl = 18'sd0 - $signed({2'b00, sx_r[15:0]});
  assign dxr = 18'sd65536 - $signed({2'b00, sx_r[15:0]});
  assign dyb = 18'sd0 - $signed({2'b00, sy_r[15:0]});
  assign dyt = 18'sd65536 - $signed({2'b00, sy_r[15:0]});

  assign term     = ((70'(pn_hi_r) <<< 23) + 70'(pn_lo_r)) >>> 14;
  assign amp_full = {pa_hi_r, 23'd0} + 61'(pa_lo_r);
  assign mx_dbl   = {mx_r, 1'b0};
  assign my_dbl   = {my_r, 1'b0};

  assign out_free = !out_valid_r || out_tready;
  assign item_pop = (state_r == ST_IDLE) && item_valid;
  assign busy     = (state_r != ST_IDLE);

  // table addresses: inner lookups first, then the two outer pairs
  always_comb begin
    case (state_r)
      ST_ADDR: begin
        addr_a = py0;
        addr_b = py1;
      end
      ST_RD_IN: begin
        addr_a = 8'(px0_r + rd_a_r);
        addr_b = 8'(px1_r + rd_a_r);
      end
      ST_RD_B: begin
        addr_a = 8'(px0_r + inner1_r);
        addr_b = 8'(px1_r + inner1_r);
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_pop && !item.is_sample) begin
      table_r[item.entry_index] <= item.entry_value;
    end
    rd_a_r <= table_r[addr_a];
    rd_b_r <= table_r[addr_b];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (item_valid && item.is_sample) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_INIT;
      ST_INIT:  state_nxt = (cfg.octaves == 5'd0) ? ST_DONE : ST_SCALE;
      ST_SCALE: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_RD_IN;
      ST_RD_IN: state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_RD_T;
      ST_RD_T:  state_nxt = ST_DOT_T;
      ST_DOT_T: state_nxt = ST_LERP1;
      ST_LERP1: state_nxt = ST_LERP2;
      ST_LERP2: state_nxt = ST_TMUL;
      ST_TMUL:  state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = (5'(k_r + 5'd1) == cfg.octaves) ? ST_DONE : ST_SCALE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        neg_x_r <= item.neg_x;
        neg_y_r <= item.neg_y;
        mag_x_r <= item.mag_x;
        mag_y_r <= item.mag_y;
      end
      ST_MUL: begin
        prod_x_r <= {32'd0, mag_x_r} * {32'd0, cfg.freq};
        prod_y_r <= {32'd0, mag_y_r} * {32'd0, cfg.freq};
      end
      ST_INIT: begin
        mx_r    <= (prod_x_r > 64'(pnd_pkg::M_CAP)) ? pnd_pkg::M_CAP : MW'(prod_x_r);
        my_r    <= (prod_y_r > 64'(pnd_pkg::M_CAP)) ? pnd_pkg::M_CAP : MW'(prod_y_r);
        amp_r   <= pnd_pkg::AMP_ONE;
        total_r <= '0;
        k_r     <= '0;
        sat_r   <= 1'b0;
      end
      ST_SCALE: begin
        sx_r  <= scl_x[31:0];
        sy_r  <= scl_y[31:0];
        sat_r <= sat_r | scl_x[32] | scl_y[32];
      end
      ST_ADDR: begin
        px0_r <= cell_idx(x0);
        px1_r <= cell_idx(17'(x0 + 17'sd1));
      end
      ST_RD_IN: begin
        inner1_r <= rd_b_r;
      end
      ST_RD_B: begin
        g_bl_r <= mod7(rd_a_r);
        g_br_r <= mod7(rd_b_r);
      end
      ST_RD_T: begin
        g_tl_r <= mod7(rd_a_r);
        g_tr_r <= mod7(rd_b_r);
        w_bl_r <= dot(dxl, dyb, grad_sel(cfg, g_bl_r));
        w_br_r <= dot(dxr, dyb, grad_sel(cfg, g_br_r));
      end
      ST_DOT_T: begin
        w_tl_r <= dot(dxl, dyt, grad_sel(cfg, g_tl_r));
        w_tr_r <= dot(dxr, dyt, grad_sel(cfg, g_tr_r));
      end
      ST_LERP1: begin
        a_r <= lerp(w_tl_r, w_tr_r, ux);
        b_r <= lerp(w_bl_r, w_br_r, ux);
      end
      ST_LERP2: begin
        n_r <= lerp(b_r, a_r, uy);
      end
      ST_TMUL: begin
        // amplitude split into two 23-bit halves
        pn_lo_r <= 46'(n_r) * $signed({23'd0, amp_r[22:0]});
        pn_hi_r <= 46'(n_r) * $signed({23'd0, amp_r[45:23]});
        pa_lo_r <= {15'd0, amp_r[22:0]} * {23'd0, cfg.persist};
        pa_hi_r <= {15'd0, amp_r[45:23]} * {23'd0, cfg.persist};
      end
      ST_ACCUM: begin
        total_r <= total_r + 64'(term);
        amp_r   <= 46'(amp_full >> 14);
        mx_r    <= (mx_dbl > (MW + 1)'(pnd_pkg::M_CAP)) ? pnd_pkg::M_CAP : MW'(mx_dbl);
        my_r    <= (my_dbl > (MW + 1)'(pnd_pkg::M_CAP)) ? pnd_pkg::M_CAP : MW'(my_dbl);
        k_r     <= 5'(k_r + 5'd1);
      end
      ST_DONE: begin
        if (out_free) begin
          if (total_r > 64'sd2147483647) begin
            out_noise_r <= 32'h7FFFFFFF;
            out_sat_r   <= 1'b1;
          end else if (total_r < -64'sd2147483648) begin
            out_noise_r <= 32'h80000000;
            out_sat_r   <= 1'b1;
          end else begin
            out_noise_r <= total_r[31:0];
            out_sat_r   <= sat_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_noise  = out_noise_r;
  assign out_sat    = out_sat_r;

endmodule

>>> verif/noise_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_checker
// Watches the item, result and register ports of the octave noise block,
// computes the expected octave sum of each sample item and compares it
// field by field with the results in order.
// ----------------------------------------------------------------------------
module noise_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [79:0]                   in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [31:0]                   out_tdata,
  input  logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [pnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  output int                            errors,
  output int                            pending
);

  typedef struct {
    logic [31:0] noise;
    logic        sat;
  } noise_result_t;

  pnd_pkg::cfg_t regs;
  logic [7:0]    perm [pnd_pkg::TABLE_SIZE];
  noise_result_t noise_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint scaled_coord(input logic [31:0] raw, input int k,
                                          inout bit sat);
    longint p;
    longint unsigned mag, d, cap, m, q;
    int i;
    p   = longint'(signed'(raw));
    mag = (p < 0) ? longint'(-p) : p;
    d   = 64'd256 << 16;
    cap = d << 33;
    m   = mag * longint'(regs.freq);
    if (m > cap) m = cap;
    for (i = 0; i < k && m < cap; i++) begin
      m = m << 1;
      if (m > cap) m = cap;
    end
    if (p >= 0) begin
      q = m / d;
      if (q > 64'h7FFF_FFFF) begin
        q   = 64'h7FFF_FFFF;
        sat = 1;
      end
      return longint'(q);
    end
    q = (m + d - 1) / d;
    if (q > 64'h8000_0000) begin
      q   = 64'h8000_0000;
      sat = 1;
    end
    return -longint'(q);
  endfunction

  function automatic longint fade_q16(input longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    q  = ((t * (6 * t - 15 * 65536)) >>> 16) + 10 * 65536;
    return (t3 * q) >>> 16;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint corner_dot(input longint cx, input longint cy,
                                        input longint dx, input longint dy);
    int px, py, g;
    logic [31:0] word;
    longint gx, gy;
    px = int'((cx < 0 ? -cx : cx) % pnd_pkg::TABLE_SIZE);
    py = int'((cy < 0 ? -cy : cy) % pnd_pkg::TABLE_SIZE);
    g  = perm[(px + perm[py]) % pnd_pkg::TABLE_SIZE] % 7;
    case (g)
      0: word = regs.grad01[31:0];
      1: word = regs.grad01[63:32];
      2: word = regs.grad23[31:0];
      3: word = regs.grad23[63:32];
      4: word = regs.grad45[31:0];
      5: word = regs.grad45[63:32];
      default: word = regs.grad6;
    endcase
    gx = longint'(signed'(word[15:0]));
    gy = longint'(signed'(word[31:16]));
    return (dx * gx + dy * gy) >>> 14;
  endfunction

  function automatic longint lattice_noise(input longint px, input longint py);
    longint fx, fy, x0, y0, tl, tr, bl, br, ux, uy;
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    x0 = px >>> 16;
    y0 = py >>> 16;
    tl = corner_dot(x0,     y0 + 1, -fx,         65536 - fy);
    tr = corner_dot(x0 + 1, y0 + 1, 65536 - fx, 65536 - fy);
    bl = corner_dot(x0,     y0,     -fx,         -fy);
    br = corner_dot(x0 + 1, y0,     65536 - fx, -fy);
    ux = fade_q16(fx);
    uy = fade_q16(fy);
    return blend(blend(bl, br, ux), blend(tl, tr, ux), uy);
  endfunction

  function automatic noise_result_t octave_sum(input logic [31:0] x, input logic [31:0] y);
    noise_result_t r;
    bit sat;
    longint total, amp, sx, sy;
    sat   = 0;
    total = 0;
    amp   = 16384;
    for (int k = 0; k < int'(regs.octaves); k++) begin
      sx    = scaled_coord(x, k, sat);
      sy    = scaled_coord(y, k, sat);
      total += (lattice_noise(sx, sy) * amp) >>> 14;
      amp   = (amp * longint'(regs.persist)) >>> 14;
    end
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      sat   = 1;
    end
    if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      sat   = 1;
    end
    r.noise = total[31:0];
    r.sat   = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    noise_result_t want;
    if (!rst_n) begin
      regs.grad01  <= '0;
      regs.grad23  <= '0;
      regs.grad45  <= '0;
      regs.grad6   <= '0;
      regs.octaves <= 5'd1;
      regs.freq    <= 32'd16777216;
      regs.persist <= 15'd8192;
      noise_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pnd_pkg::CFG_GRAD01:  regs.grad01  <= cfg_wdata;
          pnd_pkg::CFG_GRAD23:  regs.grad23  <= cfg_wdata;
          pnd_pkg::CFG_GRAD45:  regs.grad45  <= cfg_wdata;
          pnd_pkg::CFG_GRAD6:   regs.grad6   <= cfg_wdata[31:0];
          pnd_pkg::CFG_OCTAVES: regs.octaves <= cfg_wdata[4:0];
          pnd_pkg::CFG_FREQ:    regs.freq    <= cfg_wdata[31:0];
          pnd_pkg::CFG_PERSIST: regs.persist <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (noise_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result noise=%h sat=%b", $time, out_tdata, out_tuser);
        end else begin
          want = noise_q.pop_front();
          if (out_tdata !== want.noise) begin
            errors++;
            $display("%0t: noise_value expected %h actual %h", $time, want.noise, out_tdata);
          end
          if (out_tuser !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, want.sat, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == pnd_pkg::CMD_LOAD) perm[in_tdata[7:0]] = in_tdata[15:8];
        else noise_q.push_back(octave_sum(in_tdata[47:16], in_tdata[79:48]));
      end
    end
    pending = noise_q.size();
  end

endmodule

>>> verif/perlin_noise_2d_octaves_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves_test
// Fills the permutation table, then runs directed and random load and sample
// items through several register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module perlin_noise_2d_octaves_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // entry_index, entry_value, point_x, point_y
  logic        in_tuser = 0;    // command
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;       // noise_value
  logic        out_tuser;       // saturated
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  int          errors, pending;
  int          send_idle = 7, recv_idle = 46;
  int          hold_cnt = 0;
  logic        hold_go = 0;

  always #4 clk = ~clk;

  perlin_noise_2d_octaves u_top (.*);

  noise_checker u_checker (.*);

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt   <= 400;
      out_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                           input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {y, x, val, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic sample_at(input logic [31:0] x, input logic [31:0] y);
    send_item(pnd_pkg::CMD_SAMPLE, 8'($urandom), 8'($urandom), x, y);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
  endfunction

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35)
        send_item(pnd_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
      else sample_at(rand_coord(), rand_coord());
    end
  endtask

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // the whole table is written before the first sample
    for (int i = 0; i < pnd_pkg::TABLE_SIZE; i++)
      send_item(pnd_pkg::CMD_LOAD, 8'(i),
                (i == 0) ? 8'd255 : (i == 255) ? 8'd0 : 8'($urandom), $urandom,
                $urandom);
    drain();
    reg_write(pnd_pkg::CFG_GRAD01, {$urandom, $urandom});
    reg_write(pnd_pkg::CFG_GRAD23, {$urandom, $urandom});
    reg_write(pnd_pkg::CFG_GRAD45, {$urandom, $urandom});
    reg_write(pnd_pkg::CFG_GRAD6, {$urandom, $urandom});
    cfg_we <= 0;

    // directed: coordinate extremes, fractions and load extremes
    sample_at(32'h0, 32'h0);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    sample_at(32'hFFFF_FFFF, 32'h0000_0001);
    sample_at(32'h0000_FFFF, 32'hFFFF_0000);
    sample_at(32'h0001_8000, 32'hFFFE_8000);
    sample_at(32'h00FF_FFFF, 32'hFF00_0001);
    send_item(pnd_pkg::CMD_LOAD, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h0);
    send_item(pnd_pkg::CMD_LOAD, 8'd255, 8'd255, 32'h0, 32'hFFFF_FFFF);
    sample_at(32'h0000_8000, 32'h0000_8000);
    sample_at(32'h0100_0000, 32'hFF00_0000);
    random_items(100);

    for (int ph = 1; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin
          // no octaves, extreme gradient components
          reg_write(pnd_pkg::CFG_OCTAVES, 64'd0);
          reg_write(pnd_pkg::CFG_GRAD01, 64'h8000_7FFF_7FFF_8000);
          reg_write(pnd_pkg::CFG_GRAD6, 64'h8000_8000);
        end
        2: begin
          reg_write(pnd_pkg::CFG_OCTAVES, 64'd16);
          reg_write(pnd_pkg::CFG_FREQ, 64'd1);
          reg_write(pnd_pkg::CFG_PERSIST, 64'd32767);
          reg_write(pnd_pkg::CFG_GRAD23, 64'h7FFF_7FFF_7FFF_7FFF);
          reg_write(pnd_pkg::CFG_GRAD45, 64'h8000_8000_8000_8000);
        end
        3: begin
          // full register range of octaves with a huge frequency
          reg_write(pnd_pkg::CFG_OCTAVES, 64'd31);
          reg_write(pnd_pkg::CFG_FREQ, 64'hFFFF_FFFF);
          reg_write(pnd_pkg::CFG_PERSIST, 64'd8192);
          reg_write(pnd_pkg::CFG_GRAD01, {$urandom, $urandom});
        end
        4: begin
          reg_write(pnd_pkg::CFG_OCTAVES, 64'($urandom_range(1, 6)));
          reg_write(pnd_pkg::CFG_FREQ, 64'($urandom_range(32'hFFFF_FFFF, 1)));
          reg_write(pnd_pkg::CFG_PERSIST, 64'd0);
          reg_write(pnd_pkg::CFG_GRAD45, {$urandom, $urandom});
        end
        default: begin
          reg_write(pnd_pkg::CFG_OCTAVES, 64'd3);
          reg_write(pnd_pkg::CFG_FREQ, 64'($urandom_range(32'h0400_0000, 32'h0001_0000)));
          reg_write(pnd_pkg::CFG_PERSIST, 64'($urandom_range(32767)));
          reg_write(pnd_pkg::CFG_GRAD6, 64'($urandom));
        end
      endcase
      cfg_we <= 0;
      if (ph == 2) begin
        send_idle = 46;
        recv_idle = 7;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 4) begin
        // long receiver hold-off while items keep coming
        hold_go <= 1;
        @(posedge clk);
        hold_go <= 0;
        for (int i = 0; i < 12; i++) sample_at(rand_coord(), rand_coord());
      end
      random_items(ph == 3 ? 30 : 100);
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
src/pnd_pkg.sv
src/pnd_front.sv
src/pnd_fade.sv
src/pnd_back.sv
src/perlin_noise_2d_octaves.sv
verif/noise_checker.sv
verif/perlin_noise_2d_octaves_test.sv
